// ----- hw/rtl/pli_pkg.sv -----
// Shared types and constants for the piecewise-linear interpolator.
`timescale 1ns / 1ps

package pli_pkg;

    // Default table depth
    localparam int MAX_POINTS_DEF = 16;

    // Field widths
    localparam int COORD_W = 16;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // Bit-serial divide takes one quotient bit per cycle; multiply shares its step count
    localparam int SERIAL_STEPS = 17;
    localparam int STEP_W       = 5;

    // Operation carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Where the query landed on the curve
    typedef enum logic [1:0] {
        FELL_INTERP = 2'd0,
        FELL_BELOW  = 2'd1,
        FELL_ABOVE  = 2'd2,
        FELL_EMPTY  = 2'd3
    } fell_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/piecewise_linear_interpolator_core.sv -----
// Piecewise-linear interpolator: breakpoint table, search sequencer, bit-serial divide and multiply.
`timescale 1ns / 1ps

// A write beat (tuser 0) stores one breakpoint and returns nothing. An evaluate beat (tuser
// 1) returns one result beat. The two breakpoint tables each have one write port and one
// registered read port, so the search walks the table one entry per cycle: entry 0 and the
// last entry in use are checked first, which settles empty, below-first and above-last
// queries. An interpolating query then scans k entries (1 to n-1), runs a 17-step restoring
// divider (one quotient bit a cycle), a 17-step shift-add multiplier sharing the quotient
// register, an add-and-saturate state and a hand-off state that waits for a free output
// register. The result sits in its own output register, so the next beat is taken while a
// result waits downstream. No clearing pass is needed after reset; breakpoints must be
// written before point_count covers them.
module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: point_count
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // point_index[3:0], point_x[19:4], point_y[35:20],
                                    // query_x[51:36], zero [55:52]
    input  logic [0:0]  s_tuser,    // operation[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // result_y[15:0]
    output logic [1:0]  m_tuser     // where_fell[1:0]
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NW = (CW > pli_pkg::COUNT_W) ? CW : pli_pkg::COUNT_W;

    // Input beat fields
    logic                         s_operation;
    logic [pli_pkg::INDEX_W-1:0]  s_point_index;
    logic signed [15:0]           s_point_x;
    logic signed [15:0]           s_point_y;
    logic signed [15:0]           s_query_x;

    assign s_operation   = s_tuser[0];
    assign s_point_index = s_tdata[3:0];
    assign s_point_x     = s_tdata[19:4];
    assign s_point_y     = s_tdata[35:20];
    assign s_query_x     = s_tdata[51:36];

    // Control state
    pli_pkg::state_t              state_reg, state_next;
    logic [pli_pkg::COUNT_W-1:0]  point_count_reg;
    logic                         out_valid_reg, out_valid_next;

    // Datapath registers
    logic signed [15:0]           q_reg, q_next;
    logic [CW-1:0]                n_reg, n_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic signed [15:0]           x0_reg, x0_next;
    logic signed [15:0]           y0_reg, y0_next;
    logic [15:0]                  den_reg, den_next;
    logic signed [16:0]           dy_reg, dy_next;
    logic [15:0]                  rem_reg, rem_next;
    logic [16:0]                  work_reg, work_next;
    logic signed [18:0]           acc_reg, acc_next;
    logic [pli_pkg::STEP_W-1:0]   step_reg, step_next;
    logic signed [15:0]           res_y_reg, res_y_next;
    pli_pkg::fell_t               res_fell_reg, res_fell_next;
    logic signed [15:0]           out_y_reg;
    pli_pkg::fell_t               out_fell_reg;
    logic                         load_out;

    // Breakpoint memories
    logic signed [15:0]           abs_mem [MAX_POINTS];
    logic signed [15:0]           ord_mem [MAX_POINTS];
    logic signed [15:0]           x_rd_reg;
    logic signed [15:0]           y_rd_reg;
    logic [AW-1:0]                rd_addr;
    logic                         mem_we;

    // Helper terms
    logic [NW-1:0]                pc_ext;
    logic [CW-1:0]                n_eff;
    logic [NW-1:0]                wr_idx_ext;
    logic                         wr_in_range;
    logic [AW-1:0]                wr_addr;
    logic [CW-1:0]                n_m1;
    logic [AW-1:0]                n_last;
    logic [AW-1:0]                idx_inc;
    logic                         scan_more;
    logic [16:0]                  dq_full;
    logic [16:0]                  dx_full;
    logic [16:0]                  trial;
    logic                         trial_ge;
    logic [16:0]                  trial_sub;
    logic signed [18:0]           mul_sum;
    logic signed [20:0]           r_sum;
    logic signed [15:0]           r_sat;

    // Count clamp and write address
    assign pc_ext      = NW'(point_count_reg);
    assign n_eff       = (pc_ext > NW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_ext[CW-1:0];
    assign wr_idx_ext  = NW'(s_point_index);
    assign wr_in_range = wr_idx_ext < NW'(MAX_POINTS);
    assign wr_addr     = wr_idx_ext[AW-1:0];

    // Search terms
    assign n_m1      = n_reg - CW'(1);
    assign n_last    = n_m1[AW-1:0];
    assign idx_inc   = idx_reg + AW'(1);
    assign scan_more = (CW'(idx_reg) < n_m1) && (q_reg > x_rd_reg);

    // Segment differences, both positive once the segment is found
    assign dq_full = {q_reg[15], q_reg} - {x0_reg[15], x0_reg};
    assign dx_full = {x_rd_reg[15], x_rd_reg} - {x0_reg[15], x0_reg};

    // One restoring divide step
    assign trial     = {rem_reg, work_reg[16]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    // One shift-add multiply step
    assign mul_sum = work_reg[0] ? (acc_reg + {{2{dy_reg[16]}}, dy_reg}) : acc_reg;

    // y0 plus the product shifted down by 16, then saturate
    assign r_sum = {{5{y0_reg[15]}}, y0_reg} + {acc_reg[18], acc_reg, work_reg[16]};
    always_comb
    begin
        if (r_sum > 21'sd32767)
        begin
            r_sat = 16'sh7FFF;
        end
        else if (r_sum < -21'sd32768)
        begin
            r_sat = -16'sh8000;
        end
        else
        begin
            r_sat = r_sum[15:0];
        end
    end

    assign s_tready = (state_reg == pli_pkg::ST_IDLE);

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next    = state_reg;
        q_next        = q_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        x0_next       = x0_reg;
        y0_next       = y0_reg;
        den_next      = den_reg;
        dy_next       = dy_reg;
        rem_next      = rem_reg;
        work_next     = work_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        res_y_next    = res_y_reg;
        res_fell_next = res_fell_reg;
        rd_addr       = '0;
        mem_we        = 1'b0;
        load_out      = 1'b0;

        unique case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_operation == pli_pkg::OP_EVAL)
                    begin
                        q_next = s_query_x;
                        n_next = n_eff;
                        if (n_eff == '0)
                        begin
                            res_y_next    = '0;
                            res_fell_next = pli_pkg::FELL_EMPTY;
                            state_next    = pli_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = pli_pkg::ST_FIRST;
                        end
                    end
                    else
                    begin
                        mem_we = wr_in_range;
                    end
                end
            end

            // entry 0 on the read port
            pli_pkg::ST_FIRST:
            begin
                x0_next = x_rd_reg;
                y0_next = y_rd_reg;
                rd_addr = n_last;
                if (q_reg <= x_rd_reg)
                begin
                    res_y_next    = y_rd_reg;
                    res_fell_next = pli_pkg::FELL_BELOW;
                    state_next    = pli_pkg::ST_DONE;
                end
                else
                begin
                    state_next = pli_pkg::ST_LAST;
                end
            end

            // last entry in use on the read port
            pli_pkg::ST_LAST:
            begin
                rd_addr  = AW'(1);
                idx_next = AW'(1);
                if (q_reg >= x_rd_reg)
                begin
                    res_y_next    = y_rd_reg;
                    res_fell_next = pli_pkg::FELL_ABOVE;
                    state_next    = pli_pkg::ST_DONE;
                end
                else
                begin
                    state_next = pli_pkg::ST_SCAN;
                end
            end

            // walk until the first x at or above the query
            pli_pkg::ST_SCAN:
            begin
                if (scan_more)
                begin
                    x0_next  = x_rd_reg;
                    y0_next  = y_rd_reg;
                    idx_next = idx_inc;
                    rd_addr  = idx_inc;
                end
                else
                begin
                    den_next   = dx_full[15:0];
                    dy_next    = {y_rd_reg[15], y_rd_reg} - {y0_reg[15], y0_reg};
                    rem_next   = {1'b0, dq_full[15:1]};
                    work_next  = {dq_full[0], 16'h0000};
                    step_next  = pli_pkg::STEP_W'(pli_pkg::SERIAL_STEPS - 1);
                    state_next = pli_pkg::ST_DIV;
                end
            end

            // one quotient bit a cycle
            pli_pkg::ST_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[15:0] : trial[15:0];
                work_next = {work_reg[15:0], trial_ge};
                step_next = step_reg - pli_pkg::STEP_W'(1);
                if (step_reg == '0)
                begin
                    acc_next   = '0;
                    step_next  = pli_pkg::STEP_W'(pli_pkg::SERIAL_STEPS - 1);
                    state_next = pli_pkg::ST_MUL;
                end
            end

            // one multiplier bit a cycle, product shifts right through acc and work
            pli_pkg::ST_MUL:
            begin
                acc_next  = {mul_sum[18], mul_sum[18:1]};
                work_next = {mul_sum[0], work_reg[16:1]};
                step_next = step_reg - pli_pkg::STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = pli_pkg::ST_ADD;
                end
            end

            pli_pkg::ST_ADD:
            begin
                res_y_next    = r_sat;
                res_fell_next = pli_pkg::FELL_INTERP;
                state_next    = pli_pkg::ST_DONE;
            end

            // hand the result to the output register once it is free
            pli_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = pli_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase
    end

    // Output handshake
    assign out_valid_next = load_out | (out_valid_reg & ~m_tready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pli_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            point_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                point_count_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        den_reg      <= den_next;
        dy_reg       <= dy_next;
        rem_reg      <= rem_next;
        work_reg     <= work_next;
        acc_reg      <= acc_next;
        step_reg     <= step_next;
        res_y_reg    <= res_y_next;
        res_fell_reg <= res_fell_next;
        if (load_out)
        begin
            out_y_reg    <= res_y_reg;
            out_fell_reg <= res_fell_reg;
        end
    end

    // Breakpoint tables, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            abs_mem[wr_addr] <= s_point_x;
            ord_mem[wr_addr] <= s_point_y;
        end
        x_rd_reg <= abs_mem[rd_addr];
        y_rd_reg <= ord_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_y_reg;
    assign m_tuser  = out_fell_reg;

`ifndef ASSERT_OFF
    // partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pli_pkg::ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder reached divisor");

    // chosen segment always has a positive width
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pli_pkg::ST_DIV) |-> (den_reg != '0))
        else $error("zero-width segment entered the divider");

    // fraction never exceeds one
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pli_pkg::ST_DIV && step_reg == '0) |=> (work_reg <= 17'd65536))
        else $error("interpolation fraction above one");

    // scan stays within the points in use
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pli_pkg::ST_SCAN) |-> (CW'(idx_reg) < n_reg))
        else $error("search ran past the last point");

    // a result is only handed over when the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && out_valid_reg) |-> m_tready)
        else $error("pending result overwritten");
`endif

endmodule
